// ===== src/cln_pkg.sv =====
// Shared types, constants and nibble sequence decode for the character-LCD nibble writer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cln_pkg;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int NIB_W    = 4;
  localparam int POS_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int SLOT_W   = 4;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_SHUT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_MODE_SET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_LINES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON      = 3'd4;

  localparam logic [POS_W-1:0]  CHAR_LIMIT_RESET = 7'd40;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'h0A;

  // Slot numbers inside each canonical job sequence.
  localparam logic [SLOT_W-1:0] CHAR_SLOT_CLEAR = 4'd0;
  localparam logic [SLOT_W-1:0] CHAR_SLOT_HIGH  = 4'd2;
  localparam logic [SLOT_W-1:0] CHAR_SLOT_LOW   = 4'd3;
  localparam logic [SLOT_W-1:0] CHAR_SLOT_WAIT  = 4'd1;
  localparam logic [SLOT_W-1:0] INIT_SLOT_FIRST = 4'd0;
  localparam logic [SLOT_W-1:0] INIT_SLOT_DISP  = 4'd3;
  localparam logic [SLOT_W-1:0] INIT_SLOT_LAST  = 4'd8;
  localparam logic [SLOT_W-1:0] SHUT_SLOT_FIRST = 4'd0;
  localparam logic [SLOT_W-1:0] SHUT_SLOT_LAST  = 4'd3;

  typedef enum logic [1:0] {
    JOB_CHAR,
    JOB_INIT,
    JOB_SHUT
  } job_kind_t;

  // One classified item: which sequence, where it starts and ends, and its data.
  // For init jobs the data byte carries {mode_set, two_lines, cursor, blink} in bits 3:0.
  typedef struct packed {
    job_kind_t         kind;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] final_slot;
    logic [CHAR_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic             reg_select;
    logic [NIB_W-1:0] nibble;
    logic             long_wait;
  } nib_t;

  function automatic nib_t slot_nibble(job_t j, logic [SLOT_W-1:0] idx);
    nib_t n;
    n = '{reg_select: 1'b0, nibble: 4'h0, long_wait: 1'b0};
    case (j.kind)
      JOB_CHAR: begin
        case (idx)
          CHAR_SLOT_WAIT: begin
            n.nibble    = 4'h1;
            n.long_wait = 1'b1;
          end
          CHAR_SLOT_HIGH: begin
            n.reg_select = 1'b1;
            n.nibble     = j.data[7:4];
          end
          CHAR_SLOT_LOW: begin
            n.reg_select = 1'b1;
            n.nibble     = j.data[3:0];
          end
          default: n.nibble = 4'h0;
        endcase
      end
      JOB_INIT: begin
        case (idx)
          4'd0, 4'd1: n.nibble = 4'h2;
          4'd2:       n.nibble = {j.data[2], 3'b010};
          4'd4:       n.nibble = {2'b11, j.data[1], j.data[0]};
          4'd6:       n.nibble = 4'h6;
          4'd8:       n.nibble = 4'h1;
          default:    n.nibble = 4'h0;
        endcase
      end
      JOB_SHUT: begin
        case (idx)
          4'd1:    n.nibble = 4'h8;
          4'd3:    n.nibble = 4'h1;
          default: n.nibble = 4'h0;
        endcase
      end
      default: n.nibble = 4'h0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/cln_if.sv =====
// Input and result channel interfaces (valid/ready with payload).
// Depends on cln_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface cln_in_if import cln_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output operation, output char_code, input ready);
  modport sink   (input valid, input operation, input char_code, output ready);
endinterface

interface cln_out_if import cln_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             reg_select;
  logic [NIB_W-1:0] nibble;
  logic             long_wait;
  logic             last;

  modport source (output valid, output reg_select, output nibble, output long_wait,
                  output last, input ready);
  modport sink   (input valid, input reg_select, input nibble, input long_wait,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== src/cln_front.sv =====
// Front end: configuration registers, position count and item classification.
// Depends on cln_pkg and cln_if.
`timescale 1ns / 1ps
`default_nettype none
module cln_front import cln_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cln_in_if.sink                     in_ch,
  output job_t                       job,
  output logic                       job_valid,
  input  wire logic                  job_ready
);

  logic [POS_W-1:0] char_limit_r;
  logic             send_mode_set_r;
  logic             two_lines_r;
  logic             cursor_on_r;
  logic             blink_on_r;
  logic [POS_W-1:0] position_r, position_nxt;

  logic accept;
  logic wrap;
  logic has_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_limit_r    <= CHAR_LIMIT_RESET;
      send_mode_set_r <= 1'b1;
      two_lines_r     <= 1'b0;
      cursor_on_r     <= 1'b1;
      blink_on_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHAR_LIMIT:    char_limit_r    <= cfg_data;
        CFG_SEND_MODE_SET: send_mode_set_r <= cfg_data[0];
        CFG_TWO_LINES:     two_lines_r     <= cfg_data[0];
        CFG_CURSOR_ON:     cursor_on_r     <= cfg_data[0];
        CFG_BLINK_ON:      blink_on_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = job_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wrap        = (position_r >= char_limit_r);
  assign has_char    = (in_ch.char_code != NEWLINE_CODE);

  always_comb begin
    job          = '{kind: JOB_CHAR, first: CHAR_SLOT_CLEAR, final_slot: CHAR_SLOT_LOW,
                     data: in_ch.char_code};
    job_valid    = 1'b0;
    position_nxt = position_r;
    case (in_ch.operation)
      OP_WRITE: begin
        job.first      = wrap ? CHAR_SLOT_CLEAR : CHAR_SLOT_HIGH;
        job.final_slot = has_char ? CHAR_SLOT_LOW : CHAR_SLOT_WAIT;
        job_valid      = in_ch.valid && (wrap || has_char);
        if (accept) begin
          position_nxt = (wrap ? '0 : position_r) + {{(POS_W-1){1'b0}}, has_char};
        end
      end
      OP_INIT: begin
        job.kind       = JOB_INIT;
        job.first      = send_mode_set_r ? INIT_SLOT_FIRST : INIT_SLOT_DISP;
        job.final_slot = INIT_SLOT_LAST;
        job.data       = {4'h0, send_mode_set_r, two_lines_r, cursor_on_r, blink_on_r};
        job_valid      = in_ch.valid;
        if (accept) begin
          position_nxt = '0;
        end
      end
      OP_SHUT: begin
        job.kind       = JOB_SHUT;
        job.first      = SHUT_SLOT_FIRST;
        job.final_slot = SHUT_SLOT_LAST;
        job_valid      = in_ch.valid;
      end
      default: job_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/cln_queue.sv =====
// Two-entry job queue between the front end and the nibble sequencer.
// Depends on cln_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cln_queue import cln_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t wr_job,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output job_t      rd_job,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  job_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/cln_back.sv =====
// Back end: steps through a job's nibble sequence, one nibble per accepted result.
// Depends on cln_pkg and cln_if.
`timescale 1ns / 1ps
`default_nettype none
module cln_back import cln_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t job,
  input  wire logic job_valid,
  output logic      job_ready,
  cln_out_if.source out_ch
);

  job_t              cur_job_r;
  logic              cur_valid_r;
  logic [SLOT_W-1:0] idx_r;
  nib_t              cur_nib;
  logic              is_last;
  logic              fire;

  assign cur_nib   = slot_nibble(cur_job_r, idx_r);
  assign is_last   = (idx_r == cur_job_r.final_slot);
  assign fire      = out_ch.valid && out_ch.ready;
  assign job_ready = !cur_valid_r || (fire && is_last);

  assign out_ch.valid      = cur_valid_r;
  assign out_ch.reg_select = cur_nib.reg_select;
  assign out_ch.nibble     = cur_nib.nibble;
  assign out_ch.long_wait  = cur_nib.long_wait;
  assign out_ch.last       = is_last;

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur_job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (job_ready) begin
      cur_valid_r <= job_valid;
      idx_r       <= job.first;
    end else if (fire) begin
      idx_r <= idx_r + 4'd1;
    end
  end

endmodule
`default_nettype wire

// ===== src/char_lcd_nibble_writer.sv =====
// Top level of the character-LCD nibble writer: front end, job queue, nibble sequencer.
// Depends on cln_pkg, cln_if, cln_front, cln_queue and cln_back.
//
// Turns write-character, init and shutdown items into 4-bit LCD bus writes. Each result
// item is one enable strobe: reg_select, the D7..D4 nibble, long_wait (set on the last
// nibble of the automatic wrap clear; hold the bus about 100 ms after it) and last (set
// on the final nibble caused by an input item). Characters go out high nibble first with
// reg_select high; a newline shows nothing but can still trigger the wrap clear once the
// character count has reached the character limit. Rate: the sequencer emits one nibble
// per cycle while out_ch is ready; the front end takes one item per cycle while the
// two-entry job queue has room. Items that cause no result (a newline without wrap,
// operation 3) are dropped at the front end. Write configuration only while the block
// is idle.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_writer import cln_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cln_in_if.sink                     in_ch,
  cln_out_if.source                  out_ch
);

  // Classified jobs from the front end into the queue.
  job_t front_job;
  logic front_valid;
  logic front_ready;

  // Jobs from the queue into the sequencer.
  job_t back_job;
  logic back_valid;
  logic back_ready;

  // Hold config and position; classify each item into a job.
  cln_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Decouple acceptance from nibble output so either side can stall.
  cln_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (back_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  // Advance through each job's nibbles; load the next job on the last accepted nibble.
  cln_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_char_lcd_nibble_writer.sv =====
// Self-checking testbench for the character-LCD nibble writer: directed and random items,
// each bus write checked against a built-in predictor. Depends on cln_pkg, cln_if and the RTL.
`timescale 1ns / 1ps
module tb_char_lcd_nibble_writer;
  import cln_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int DRAIN_CYCLES   = 12;   // sequencer plus two-entry job queue, with margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;

  // One expected bus write: select level, data lines, long-wait flag, end of item.
  typedef struct packed {
    logic             reg_select;
    logic [NIB_W-1:0] nibble;
    logic             long_wait;
    logic             last;
  } bus_wr_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cln_in_if  in_ch ();
  cln_out_if out_ch ();

  char_lcd_nibble_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow of the configuration and of the shown-character count.
  logic [POS_W-1:0] lim_chars   = CHAR_LIMIT_RESET;
  logic             use_fn_set  = 1'b1;
  logic             fn_two_line = 1'b0;
  logic             disp_cursor = 1'b1;
  logic             disp_blink  = 1'b1;
  logic [POS_W-1:0] shown_chars = '0;

  bus_wr_t expected_writes[$];
  int mismatch_count = 0;

  // Idling knobs: each side draws its wait per item from 0 up to these.
  int in_max_gap      = 8;
  int out_max_stall   = 8;
  int out_hold_cycles = 0;

  function automatic bus_wr_t make_wr(logic rs, logic [NIB_W-1:0] nib, logic lw);
    bus_wr_t w;
    w.reg_select = rs;
    w.nibble     = nib;
    w.long_wait  = lw;
    w.last       = 1'b0;
    return w;
  endfunction

  // Work out the bus writes one input item causes and queue them in order.
  task automatic predict_bus_wrs(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
    bus_wr_t w[$];
    case (op)
      OP_WRITE: begin
        // Count has hit the limit: clear first, flag the long wait, restart the count.
        if (shown_chars >= lim_chars) begin
          shown_chars = '0;
          w.push_back(make_wr(1'b0, 4'h0, 1'b0));
          w.push_back(make_wr(1'b0, 4'h1, 1'b1));
        end
        // Newline shows nothing and leaves the count alone.
        if (ch != NEWLINE_CODE) begin
          w.push_back(make_wr(1'b1, ch[7:4], 1'b0));
          w.push_back(make_wr(1'b1, ch[3:0], 1'b0));
          shown_chars = shown_chars + 1'b1;
        end
      end
      OP_INIT: begin
        if (use_fn_set) begin
          w.push_back(make_wr(1'b0, 4'h2, 1'b0));
          w.push_back(make_wr(1'b0, 4'h2, 1'b0));
          w.push_back(make_wr(1'b0, {fn_two_line, 3'b010}, 1'b0));
        end
        w.push_back(make_wr(1'b0, 4'h0, 1'b0));
        w.push_back(make_wr(1'b0, {2'b11, disp_cursor, disp_blink}, 1'b0));
        w.push_back(make_wr(1'b0, 4'h0, 1'b0));
        w.push_back(make_wr(1'b0, 4'h6, 1'b0));
        w.push_back(make_wr(1'b0, 4'h0, 1'b0));
        w.push_back(make_wr(1'b0, 4'h1, 1'b0));
        shown_chars = '0;
      end
      OP_SHUT: begin
        w.push_back(make_wr(1'b0, 4'h0, 1'b0));
        w.push_back(make_wr(1'b0, 4'h8, 1'b0));
        w.push_back(make_wr(1'b0, 4'h0, 1'b0));
        w.push_back(make_wr(1'b0, 4'h1, 1'b0));
      end
      default: ;  // unused operation: dropped, nothing changes
    endcase
    if (w.size() > 0) w[w.size()-1].last = 1'b1;
    foreach (w[i]) expected_writes.push_back(w[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Send one item: optional gap, predict, then hold valid until the block takes it.
  // The prediction is queued before acceptance so the checker never races it.
  task automatic send_lcd_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_bus_wrs(op, ch);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.char_code <= ch;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every expected write, then let items that cause nothing clear out.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers on back-to-back edges; only call with the block idle.
  task automatic apply_lcd_config(input logic [POS_W-1:0] lim, input logic fn_set,
                                  input logic two, input logic cur, input logic blink);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHAR_LIMIT;    cfg_data <= lim;
    @(posedge clk);
    lim_chars = lim;
    cfg_index <= CFG_SEND_MODE_SET; cfg_data <= {6'b0, fn_set};
    @(posedge clk);
    use_fn_set = fn_set;
    cfg_index <= CFG_TWO_LINES;     cfg_data <= {6'b0, two};
    @(posedge clk);
    fn_two_line = two;
    cfg_index <= CFG_CURSOR_ON;     cfg_data <= {6'b0, cur};
    @(posedge clk);
    disp_cursor = cur;
    cfg_index <= CFG_BLINK_ON;      cfg_data <= {6'b0, blink};
    @(posedge clk);
    disp_blink = blink;
    cfg_we <= 1'b0;
  endtask

  // Init, shutdown and the ignored opcode at reset config, then init without and with mode set.
  task automatic test_init_and_shutdown();
    send_lcd_item(OP_INIT, 8'h00);
    send_lcd_item(OP_SHUT, 8'hFF);
    send_lcd_item(2'd3, 8'h41);
    settle_block();
    apply_lcd_config(7'd40, 1'b0, 1'b1, 1'b0, 1'b1);
    send_lcd_item(OP_INIT, 8'h00);
    settle_block();
    apply_lcd_config(7'd40, 1'b1, 1'b1, 1'b1, 1'b0);
    send_lcd_item(OP_INIT, 8'h00);
    send_lcd_item(OP_SHUT, 8'h00);
    settle_block();
  endtask

  // Extreme codes, both nibble patterns, and a newline with the count below the limit.
  task automatic test_char_extremes();
    send_lcd_item(OP_WRITE, 8'h00);
    send_lcd_item(OP_WRITE, 8'hFF);
    send_lcd_item(OP_WRITE, NEWLINE_CODE);
    send_lcd_item(OP_WRITE, 8'h5A);
    send_lcd_item(OP_WRITE, 8'hA5);
    settle_block();
  endtask

  // Wrap clear at a limit of one, a newline that only clears, and the zero limit.
  task automatic test_wrap_clear();
    apply_lcd_config(7'd1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_lcd_item(OP_INIT, 8'h00);
    send_lcd_item(OP_WRITE, 8'h41);
    send_lcd_item(OP_WRITE, 8'h42);
    send_lcd_item(OP_WRITE, NEWLINE_CODE);
    send_lcd_item(OP_WRITE, NEWLINE_CODE);
    send_lcd_item(OP_WRITE, 8'h43);
    settle_block();
    apply_lcd_config(7'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_lcd_item(OP_WRITE, 8'h78);
    send_lcd_item(OP_WRITE, 8'h79);
    settle_block();
  endtask

  // Hold off the receiver for a long stretch while items keep coming back to back.
  task automatic test_output_backpressure();
    apply_lcd_config(7'd5, 1'b1, 1'b0, 1'b1, 1'b1);
    in_max_gap = 0;
    out_hold_cycles = 80;
    repeat (16) send_lcd_item(OP_WRITE, 8'($urandom_range(0, 255)));
    send_lcd_item(OP_INIT, 8'h00);
    settle_block();
    in_max_gap = 8;
  endtask

  // Random phases, each with its own configuration and idling; mostly characters.
  task automatic test_random_items();
    logic [POS_W-1:0] lim;
    int pick;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       lim = 7'd1;
        1:       lim = 7'd80;
        2:       lim = 7'd0;
        3:       lim = 7'd127;
        default: lim = 7'($urandom_range(1, 12));
      endcase
      apply_lcd_config(lim, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      // Every third phase runs both sides without any idling.
      in_max_gap    = (phase % 3 == 0) ? 0 : 8;
      out_max_stall = (phase % 3 == 0) ? 0 : 8;
      for (int n = 0; n < 22; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      send_lcd_item(OP_WRITE, 8'($urandom_range(0, 255)));
        else if (pick < 87) send_lcd_item(OP_WRITE, NEWLINE_CODE);
        else if (pick < 92) send_lcd_item(OP_INIT, 8'($urandom_range(0, 255)));
        else if (pick < 97) send_lcd_item(OP_SHUT, 8'($urandom_range(0, 255)));
        else                send_lcd_item(2'd3, 8'($urandom_range(0, 255)));
      end
      settle_block();
    end
    in_max_gap    = 8;
    out_max_stall = 8;
  endtask

  // Receiver: stall a random count per write, or hold off when asked, then take one write.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_hold_cycles > 0) begin
        stall = out_hold_cycles;
        out_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, out_max_stall);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Checker: compare each accepted write with the oldest expectation, field by field.
  always @(posedge clk) begin
    bus_wr_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write rs=%0b nib=%h", out_ch.reg_select,
                                  out_ch.nibble));
      end else begin
        exp_w = expected_writes.pop_front();
        if (out_ch.reg_select !== exp_w.reg_select)
          report_mismatch($sformatf("reg_select %0b, expected %0b", out_ch.reg_select,
                                    exp_w.reg_select));
        if (out_ch.nibble !== exp_w.nibble)
          report_mismatch($sformatf("nibble %h, expected %h", out_ch.nibble, exp_w.nibble));
        if (out_ch.long_wait !== exp_w.long_wait)
          report_mismatch($sformatf("long_wait %0b, expected %0b", out_ch.long_wait,
                                    exp_w.long_wait));
        if (out_ch.last !== exp_w.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, exp_w.last));
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d writes still expected",
             WATCHDOG_LIMIT, expected_writes.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CHAR_LIMIT;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_WRITE;
    in_ch.char_code <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_init_and_shutdown();
    test_char_extremes();
    test_wrap_clear();
    test_output_backpressure();
    test_random_items();

    settle_block();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
